@@ rtl/ffl_pkg.sv @@
package ffl_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int ADDR_W = 64;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_LOOKUP,
      OP_DROP
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   fixup;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] fixup;
   } entry_type;

   typedef struct packed {
      logic               found;
      logic [ADDR_W-1:0]  fixup_address;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ rtl/fault_fixup_lookup.sv @@
// Exception fixup table with exact-match lookup.
// Transactions enter through push/full: req_kind 0 stores the pair
// req_entry_address/req_entry_fixup at req_entry_index, req_kind 1 searches
// for req_query_address. Loads must arrive in ascending address order.
// Each lookup yields one response on the empty/pop side: rsp_found and
// rsp_fixup_address, which is zero on a miss. Loads yield no response.
// csr_wr_en/csr_wr_data set the number of entries searched; write it only
// while no transaction is in flight.
// The search unit handles one transaction at a time. A lookup holds it
// until its response is pushed, after at most ceil(log2(n + 1)) table
// probes for n entries; the table has a single read port, so the probes
// are made one after another.
// A two-entry queue on each side lets requests keep arriving while a
// response waits; when pop stays low the response queue fills, the search
// unit pauses, and then full rises. Reset empties both queues and clears
// the entry count; table contents are kept and are valid only once written.
module fault_fixup_lookup #(
   parameter int TABLE_DEPTH = ffl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_kind,
   input  logic [ffl_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_entry_address,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_entry_fixup,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_query_address,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_found,
   output logic [ffl_pkg::ADDR_W-1:0]    rsp_fixup_address,
   input  logic                          csr_wr_en,
   input  logic [ffl_pkg::COUNT_W-1:0]   csr_wr_data
);

   ffl_pkg::queue_status_type cmd_status;
   ffl_pkg::queue_status_type rsp_status;
   ffl_pkg::cmd_type          cmd;
   ffl_pkg::rsp_type          rsp_new;
   ffl_pkg::rsp_type          rsp_head;
   logic                      cmd_pop;
   logic                      rsp_push;
   logic [$bits(ffl_pkg::rsp_type)-1:0] rsp_bits;

   ffl_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_entry_address (req_entry_address),
      .req_entry_fixup   (req_entry_fixup),
      .req_query_address (req_query_address),
      .cmd_pop           (cmd_pop),
      .cmd_status        (cmd_status),
      .cmd               (cmd)
   );

   ffl_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_status  (cmd_status),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_status  (rsp_status),
      .rsp_push    (rsp_push),
      .rsp         (rsp_new)
   );

   ffl_queue #(
      .WIDTH ($bits(ffl_pkg::rsp_type)),
      .DEPTH (ffl_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_new),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .status  (rsp_status)
   );

   assign rsp_head          = rsp_bits;
   assign empty             = rsp_status.empty;
   assign rsp_found         = rsp_head.found;
   assign rsp_fixup_address = rsp_head.fixup_address;

endmodule

@@ rtl/ffl_queue.sv @@
module ffl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ffl_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   output logic [WIDTH-1:0]         rd_data,
   output ffl_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_wr = wr_en && !status.full;
   assign do_rd = rd_en && !status.empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/ffl_front.sv @@
module ffl_front #(
   parameter int TABLE_DEPTH = ffl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_kind,
   input  logic [ffl_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_entry_address,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_entry_fixup,
   input  logic [ffl_pkg::ADDR_W-1:0]    req_query_address,
   input  logic                          cmd_pop,
   output ffl_pkg::queue_status_type     cmd_status,
   output ffl_pkg::cmd_type              cmd
);

   ffl_pkg::cmd_type cmd_new;
   logic [$bits(ffl_pkg::cmd_type)-1:0] cmd_bits;

   // Loads aimed past the end of the table are kept as transactions but do nothing.
   always_comb begin
      cmd_new.index = req_entry_index;
      cmd_new.fixup = req_entry_fixup;
      if (req_kind) begin
         cmd_new.op      = ffl_pkg::OP_LOOKUP;
         cmd_new.address = req_query_address;
      end else begin
         cmd_new.address = req_entry_address;
         if (32'(req_entry_index) < TABLE_DEPTH) begin
            cmd_new.op = ffl_pkg::OP_LOAD;
         end else begin
            cmd_new.op = ffl_pkg::OP_DROP;
         end
      end
   end

   ffl_queue #(
      .WIDTH ($bits(ffl_pkg::cmd_type)),
      .DEPTH (ffl_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cmd_new),
      .rd_en   (cmd_pop),
      .rd_data (cmd_bits),
      .status  (cmd_status)
   );

   assign full = cmd_status.full;
   assign cmd  = cmd_bits;

endmodule

@@ rtl/ffl_back.sv @@
module ffl_back #(
   parameter int TABLE_DEPTH = ffl_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ffl_pkg::COUNT_W-1:0]   csr_wr_data,
   input  ffl_pkg::queue_status_type     cmd_status,
   input  ffl_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  ffl_pkg::queue_status_type     rsp_status,
   output logic                          rsp_push,
   output ffl_pkg::rsp_type              rsp
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int BND_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (BND_W > ffl_pkg::COUNT_W) ? BND_W : ffl_pkg::COUNT_W;

   ffl_pkg::entry_type mem [TABLE_DEPTH];
   ffl_pkg::entry_type rd_ff;

   ffl_pkg::state_type state_ff, state_in;
   logic [ffl_pkg::COUNT_W-1:0] count_ff;
   logic [BND_W-1:0]            lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]            mid_ff, mid_in;
   logic [ffl_pkg::ADDR_W-1:0]  query_ff, query_in;

   logic [CMP_W-1:0] count_ext;
   logic [BND_W-1:0] hi_start, mid_start;
   logic [BND_W-1:0] lo_up, mid_up, hi_down, mid_down;
   logic             up_live, down_live;
   logic             hit, go_up;
   logic             take, start_lookup;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;

   always_comb begin
      count_ext = CMP_W'(count_ff);
      if (count_ext > CMP_W'(TABLE_DEPTH)) begin
         count_ext = CMP_W'(TABLE_DEPTH);
      end
      hi_start  = count_ext[BND_W-1:0];
      mid_start = (hi_start - BND_W'(1)) >> 1;
   end

   // Both possible next probes are prepared before the compare picks one.
   always_comb begin
      lo_up     = BND_W'(mid_ff) + BND_W'(1);
      up_live   = (lo_up < hi_ff);
      mid_up    = lo_up + ((hi_ff - BND_W'(1) - lo_up) >> 1);
      hi_down   = BND_W'(mid_ff);
      down_live = (lo_ff < hi_down);
      mid_down  = lo_ff + ((hi_down - BND_W'(1) - lo_ff) >> 1);
   end

   assign hit   = (rd_ff.address == query_ff);
   assign go_up = (rd_ff.address < query_ff);

   assign take         = (state_ff == ffl_pkg::ST_IDLE) && !cmd_status.empty
                         && !rsp_status.full;
   assign start_lookup = take && (cmd.op == ffl_pkg::OP_LOOKUP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffl_pkg::ST_IDLE: begin
            if (start_lookup && (hi_start != '0)) begin
               state_in = ffl_pkg::ST_SEARCH;
            end
         end
         ffl_pkg::ST_SEARCH: begin
            if (hit || (go_up && !up_live) || (!go_up && !down_live)) begin
               state_in = ffl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop           = 1'b0;
      wr_en             = 1'b0;
      rsp_push          = 1'b0;
      rsp.found         = 1'b0;
      rsp.fixup_address = '0;
      rd_addr           = mid_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      mid_in            = mid_ff;
      query_in          = query_ff;
      case (state_ff)
         ffl_pkg::ST_IDLE: begin
            cmd_pop = take;
            wr_en   = take && (cmd.op == ffl_pkg::OP_LOAD);
            rd_addr = mid_start[IDX_W-1:0];
            if (start_lookup) begin
               lo_in    = '0;
               hi_in    = hi_start;
               mid_in   = mid_start[IDX_W-1:0];
               query_in = cmd.address;
               rsp_push = (hi_start == '0);
            end
         end
         ffl_pkg::ST_SEARCH: begin
            if (hit) begin
               rsp_push          = 1'b1;
               rsp.found         = 1'b1;
               rsp.fixup_address = rd_ff.fixup;
            end else if (go_up) begin
               lo_in    = lo_up;
               mid_in   = mid_up[IDX_W-1:0];
               rd_addr  = mid_up[IDX_W-1:0];
               rsp_push = !up_live;
            end else begin
               hi_in    = hi_down;
               mid_in   = mid_down[IDX_W-1:0];
               rd_addr  = mid_down[IDX_W-1:0];
               rsp_push = !down_live;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffl_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      query_ff <= query_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[IDX_W'(cmd.index)] <= '{address: cmd.address, fixup: cmd.fixup};
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

endmodule
